// File: rtl/hpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpd_pkg
// Types, constants and helpers shared by the HTTP packet detector modules.
// ----------------------------------------------------------------------------
package hpd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef enum logic [2:0] {
      VERDICT_HTTP         = 3'd0,
      VERDICT_NOT_IPV4     = 3'd1,
      VERDICT_NOT_TCP      = 3'd2,
      VERDICT_TRUNCATED    = 3'd3,
      VERDICT_BAD_HEADER   = 3'd4,
      VERDICT_NO_SIGNATURE = 3'd5
   } verdict_type;

   typedef struct packed {
      logic        is_http;
      verdict_type verdict;
   } rsp_word_type;

   // Every length threshold lies below 142, so frame lengths are clamped to 8 bits.
   localparam int LEN_WIDTH = 8;
   localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

   typedef struct packed {
      logic [LEN_WIDTH-1:0] frame_len;
      logic [15:0]          ether_type;
      logic [3:0]           ip_header_words;
      logic [7:0]           ip_protocol;
      logic [15:0]          datagram_length;
      logic [3:0]           tcp_header_words;
      logic [2:0]           signature_matched;
   } summary_type;

   localparam logic [7:0]  POS_ETHER_TYPE_HI = 8'd12;
   localparam logic [7:0]  POS_ETHER_TYPE_LO = 8'd13;
   localparam logic [7:0]  POS_IHL           = 8'd14;
   localparam logic [7:0]  POS_TOTAL_LEN_HI  = 8'd16;
   localparam logic [7:0]  POS_TOTAL_LEN_LO  = 8'd17;
   localparam logic [7:0]  POS_PROTOCOL      = 8'd23;
   localparam logic [7:0]  TCP_DOFF_OFFSET   = 8'd12;

   localparam logic [7:0]  ETH_LEN           = 8'd14;
   localparam logic [7:0]  ETH_IP_MIN_LEN    = 8'd34;
   localparam logic [7:0]  TCP_MIN_LEN       = 8'd20;
   localparam logic [7:0]  MIN_PAYLOAD       = 8'd7;
   localparam logic [2:0]  SIG_LEN           = 3'd4;
   localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
   localparam logic [7:0]  PROTOCOL_TCP      = 8'd6;
   localparam logic [3:0]  MIN_HEADER_WORDS  = 4'd5;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = 2;

   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h48;
         2'd1:    b = 8'h54;
         2'd2:    b = 8'h54;
         default: b = 8'h50;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// File: rtl/hpd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpd_front
// Byte parser: tracks the frame offset, captures header fields and the
// signature match, and pushes one frame summary on the final byte.
// ----------------------------------------------------------------------------
module hpd_front import hpd_pkg::*; #(
   parameter int OFFSET_WIDTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              push_valid,
   input  wire logic         push_ready,
   output summary_type       push_word
);

   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [15:0]             ether_type_ff, ether_type_in;
   logic [3:0]              ihl_ff, ihl_in;
   logic [7:0]              protocol_ff, protocol_in;
   logic [15:0]             total_len_ff, total_len_in;
   logic [3:0]              doff_ff, doff_in;
   logic [2:0]              sig_ff, sig_in;

   logic                    accept;
   logic                    pos_low;
   logic [7:0]              pos;
   logic [7:0]              tcp_start;
   logic [7:0]              doff_pos;
   logic [7:0]              pay_start;
   logic [7:0]              sig_idx;
   logic                    in_sig;
   logic [LEN_WIDTH-1:0]    frame_len;
   logic [7:0]              b;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign b         = req_word.data_byte;
   assign pos_low   = (offset_ff[OFFSET_WIDTH-1:LEN_WIDTH] == '0);
   assign pos       = offset_ff[LEN_WIDTH-1:0];
   assign tcp_start = ETH_LEN + {2'b00, ihl_ff, 2'b00};
   assign doff_pos  = tcp_start + TCP_DOFF_OFFSET;
   assign pay_start = tcp_start + {2'b00, doff_ff, 2'b00};
   assign sig_idx   = pos - pay_start;
   assign in_sig    = pos_low && (ihl_ff >= MIN_HEADER_WORDS) &&
                      (doff_ff >= MIN_HEADER_WORDS) && (pos >= pay_start) &&
                      (sig_idx < 8'd4);

   always_comb begin
      ether_type_in = ether_type_ff;
      ihl_in        = ihl_ff;
      protocol_in   = protocol_ff;
      total_len_in  = total_len_ff;
      doff_in       = doff_ff;
      sig_in        = sig_ff;
      if (pos_low && pos == POS_ETHER_TYPE_HI) begin
         ether_type_in[15:8] = b;
      end
      if (pos_low && pos == POS_ETHER_TYPE_LO) begin
         ether_type_in[7:0] = b;
      end
      if (pos_low && pos == POS_IHL) begin
         ihl_in = b[3:0];
      end
      if (pos_low && pos == POS_TOTAL_LEN_HI) begin
         total_len_in[15:8] = b;
      end
      if (pos_low && pos == POS_TOTAL_LEN_LO) begin
         total_len_in[7:0] = b;
      end
      if (pos_low && pos == POS_PROTOCOL) begin
         protocol_in = b;
      end
      if (pos_low && (ihl_ff >= MIN_HEADER_WORDS) && pos == doff_pos) begin
         doff_in = b[7:4];
      end
      if (in_sig && sig_ff == sig_idx[2:0] && b == sig_byte(sig_idx[1:0])) begin
         sig_in = sig_idx[2:0] + 3'd1;
      end
      offset_in = offset_ff;
      if (offset_ff != '1) begin
         offset_in = offset_ff + 1'b1;
      end
      if (!pos_low || pos == LEN_MAX) begin
         frame_len = LEN_MAX;
      end else begin
         frame_len = pos + 8'd1;
      end
   end

   assign push_valid = accept && req_word.last_byte;
   assign push_word  = '{frame_len:         frame_len,
                         ether_type:        ether_type_in,
                         ip_header_words:   ihl_in,
                         ip_protocol:       protocol_in,
                         datagram_length:   total_len_in,
                         tcp_header_words:  doff_in,
                         signature_matched: sig_in};

   always_ff @(posedge clock) begin
      if (reset || (accept && req_word.last_byte)) begin
         offset_ff     <= '0;
         ether_type_ff <= '0;
         ihl_ff        <= '0;
         protocol_ff   <= '0;
         total_len_ff  <= '0;
         doff_ff       <= '0;
         sig_ff        <= '0;
      end else if (accept) begin
         offset_ff     <= offset_in;
         ether_type_ff <= ether_type_in;
         ihl_ff        <= ihl_in;
         protocol_ff   <= protocol_in;
         total_len_ff  <= total_len_in;
         doff_ff       <= doff_in;
         sig_ff        <= sig_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.last_byte) |=> (offset_ff == '0 && sig_ff == '0))
      else $error("parser state not cleared after final word");

   a_sig_bounded: assert property (@(posedge clock) disable iff (reset)
      sig_ff <= SIG_LEN)
      else $error("signature count out of range");

endmodule
`default_nettype wire

// File: rtl/hpd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpd_queue
// Short first-in first-out queue of frame summaries between parser and judge.
// ----------------------------------------------------------------------------
module hpd_queue import hpd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   output logic             push_ready,
   input  wire summary_type push_word,
   output logic             pop_valid,
   input  wire logic        pop_ready,
   output summary_type      pop_word
);

   summary_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   count_ff, count_in;
   logic                       push_fire;
   logic                       pop_fire;

   assign push_ready = (count_ff != QUEUE_PTR_WIDTH'(0) + (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_WIDTH'(push_fire);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_WIDTH'(pop_fire);
      count_in  = count_ff + (QUEUE_PTR_WIDTH+1)'(push_fire)
                           - (QUEUE_PTR_WIDTH+1)'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH)) |->
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_WIDTH-1:0])
      else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// File: rtl/hpd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpd_back
// Judge: turns a frame summary into a verdict and holds it in the output
// register until the result word is taken.
// ----------------------------------------------------------------------------
module hpd_back import hpd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        pop_valid,
   output logic             pop_ready,
   input  wire summary_type pop_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_word_type     rsp_word
);

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;
   logic [5:0]          ip_len;
   logic [5:0]          tcp_len;
   logic [7:0]          tcp_start;
   logic signed [17:0]  pay_len;
   verdict_type         verdict;
   logic                load;

   assign ip_len    = {pop_word.ip_header_words, 2'b00};
   assign tcp_len   = {pop_word.tcp_header_words, 2'b00};
   assign tcp_start = ETH_LEN + {2'b00, ip_len};
   assign pay_len   = $signed({2'b00, pop_word.datagram_length})
                    - $signed({12'd0, ip_len}) - $signed({12'd0, tcp_len});

   always_comb begin
      if (pop_word.frame_len < ETH_LEN) begin
         verdict = VERDICT_TRUNCATED;
      end else if (pop_word.ether_type != ETHERTYPE_IPV4) begin
         verdict = VERDICT_NOT_IPV4;
      end else if (pop_word.frame_len < ETH_IP_MIN_LEN) begin
         verdict = VERDICT_TRUNCATED;
      end else if (pop_word.ip_protocol != PROTOCOL_TCP) begin
         verdict = VERDICT_NOT_TCP;
      end else if (pop_word.ip_header_words < MIN_HEADER_WORDS) begin
         verdict = VERDICT_BAD_HEADER;
      end else if (pop_word.frame_len < tcp_start + TCP_MIN_LEN) begin
         verdict = VERDICT_TRUNCATED;
      end else if (pop_word.tcp_header_words < MIN_HEADER_WORDS) begin
         verdict = VERDICT_BAD_HEADER;
      end else if (pay_len < $signed({10'd0, MIN_PAYLOAD})) begin
         verdict = VERDICT_BAD_HEADER;
      end else if (pop_word.frame_len < tcp_start + {2'b00, tcp_len} + MIN_PAYLOAD) begin
         verdict = VERDICT_TRUNCATED;
      end else if (pop_word.signature_matched == SIG_LEN) begin
         verdict = VERDICT_HTTP;
      end else begin
         verdict = VERDICT_NO_SIGNATURE;
      end
   end

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign load      = pop_valid && pop_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (load) begin
         rsp_valid_in        = 1'b1;
         rsp_word_in.is_http = (verdict == VERDICT_HTTP);
         rsp_word_in.verdict = verdict;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_http_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.is_http == (rsp_word_ff.verdict == VERDICT_HTTP)))
      else $error("is_http disagrees with verdict");

endmodule
`default_nettype wire

// File: rtl/http_packet_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_packet_detector
// Parses Ethernet/IPv4/TCP frames one byte per word and reports whether the
// TCP payload starts with "HTTP", with one verdict word per frame.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle while the summary queue has room;
// one verdict per cycle while rsp_ready is high. A frame's summary enters
// the queue, then the judge loads its verdict into the output register.
// A four-entry summary queue lets the parser run while results are held.
// Reset is synchronous and clears the parser, the queue and the result valid.
module http_packet_detector import hpd_pkg::*; #(
   parameter int OFFSET_WIDTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   logic        push_valid;
   logic        push_ready;
   summary_type push_word;
   logic        pop_valid;
   logic        pop_ready;
   summary_type pop_word;

   hpd_front #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word)
   );

   hpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   hpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_word  (pop_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire
